### rtl/sgsc_pkg.sv
// Package for the sexed genotype site counter: base and status codes,
// count cap, item and result layouts. No dependencies.
`default_nettype none

package sgsc_pkg;

    // Saturation bound of the genotype counts (never above what 9 bits hold)
    localparam int MAX_INDIVIDUALS = 256;
    localparam int COUNT_W         = 9;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_INDIVIDUALS < 511) ? MAX_INDIVIDUALS : 511);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 128;
    localparam int STATUS_W   = 3;

    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_N_UPPER = 8'h4E;
    localparam logic [7:0] CHAR_N_LOWER = 8'h6E;

    typedef enum logic [2:0] {
        BASE_A   = 3'd0,
        BASE_T   = 3'd1,
        BASE_G   = 3'd2,
        BASE_C   = 3'd3,
        BASE_N   = 3'd4,
        BASE_BAD = 3'd5
    } t_base_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_INVARIANT  = 3'd0,
        ST_BIALLELIC  = 3'd1,
        ST_ONE_SEX    = 3'd2,
        ST_THREE      = 3'd3,
        ST_FOUR       = 3'd4,
        ST_BAD_BYTE   = 3'd5
    } t_status;

    // One accepted individual
    typedef struct packed {
        logic [7:0] first_allele;
        logic [7:0] second_allele;
        logic       sex;
        logic       swap_order;
        logic       contig_start;
        logic       last_of_site;
    } t_item;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic [COUNT_W-1:0] male_hom_two;
        logic [COUNT_W-1:0] male_het;
        logic [COUNT_W-1:0] male_hom_one;
        logic [COUNT_W-1:0] female_hom_two;
        logic [COUNT_W-1:0] female_het;
        logic [COUNT_W-1:0] female_hom_one;
        logic [1:0]         allele_two;
        logic [1:0]         allele_one;
        logic [31:0]        segregating_sites;
        logic [31:0]        site_position;
    } t_out_data;

    function automatic t_base_code base_code(input logic [7:0] b);
        t_base_code c;
        unique case (b)
            CHAR_A:       c = BASE_A;
            CHAR_T:       c = BASE_T;
            CHAR_G:       c = BASE_G;
            CHAR_C:       c = BASE_C;
            CHAR_N_UPPER: c = BASE_N;
            CHAR_N_LOWER: c = BASE_N;
            default:      c = BASE_BAD;
        endcase
        return c;
    endfunction

    function automatic logic is_acgt(input t_base_code c);
        return (c != BASE_N) && (c != BASE_BAD);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
        return (v < COUNT_CAP) ? v + COUNT_W'(1) : COUNT_CAP;
    endfunction

endpackage

`default_nettype wire

### rtl/sexed_genotype_site_counter_core.sv
// Top level of the sexed genotype site counter: per-site genotype tally
// and site record. Depends on sgsc_pkg.
//
// Usage:
//   The slave channel takes one individual per item: tdata carries the two
//   raw allele bytes, sex and the swap bit, tuser carries the contig-start
//   flag and tlast marks the final individual of a site. The master channel
//   emits one record per closed site: tuser is the site status, tdata holds
//   position, segregating count, the two allele codes and six sexed
//   genotype counts.
//   Throughput is one item per cycle while no closing item waits for the
//   output register. Each item is captured in an input register and folded
//   into the site tallies from there; when its closing item advances, the
//   record of a site is written into an output register and shows on the
//   master channel from that register until the receiver takes it.
//   When the receiver stalls, the record holds in the output register. Items
//   that do not close a site keep flowing; a closing item waits in the input
//   register until the output register frees, and s_axis_tready drops only
//   then. Ready on the slave side is therefore combinational from
//   m_axis_tready.
//   A synchronous low reset empties both registers and clears all tallies,
//   the position and the segregating counter; no site is open afterwards.
//   Genotype counts saturate at the package cap, position and segregating
//   count at their full 32-bit range.
`default_nettype none

module sexed_genotype_site_counter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // first_allele[7:0], second_allele[15:8], sex[16], swap_order[17], zero fill
    input  wire logic [sgsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // contig_start[0]
    input  wire logic [0:0]                      s_axis_tuser,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // site_position[31:0], segregating_sites[63:32], allele_one[65:64],
    // allele_two[67:66], female_hom_one[76:68], female_het[85:77],
    // female_hom_two[94:86], male_hom_one[103:95], male_het[112:104],
    // male_hom_two[121:113], zero fill
    output logic [sgsc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status[2:0]
    output logic [sgsc_pkg::STATUS_W-1:0]        m_axis_tuser
);
    import sgsc_pkg::*;

    // Input register
    logic  r_in_valid;
    t_item r_item;

    // Site tallies
    logic [3:0]         r_seen, n_seen;
    logic               r_bad, n_bad;
    logic [COUNT_W-1:0] r_hom [8];
    logic [COUNT_W-1:0] n_hom [8];
    logic [COUNT_W-1:0] r_het [2];
    logic [COUNT_W-1:0] n_het [2];
    logic               r_mid_site;
    logic [31:0]        r_pos, n_pos;
    logic [31:0]        r_seg, n_seg;

    // Output register
    logic      r_out_valid;
    t_out_data r_out_data, n_out_data;
    t_status   r_out_status, n_out_status;

    // Stage control
    logic out_free;
    logic advance;
    logic adv_last;

    // Per-item decode
    t_base_code c1, c2;
    logic       het_item;
    logic [2:0] nb;
    logic [1:0] lo_base, hi_base, x_base, y_base;
    logic [31:0] pos_base, seg_base;

    assign out_free      = !r_out_valid || m_axis_tready;
    // Items that close no site always move on; a closing item needs room
    assign advance       = r_in_valid && (!r_item.last_of_site || out_free);
    assign adv_last      = advance && r_item.last_of_site;
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        c1       = base_code(r_item.first_allele);
        c2       = base_code(r_item.second_allele);
        het_item = (r_item.first_allele != r_item.second_allele);

        n_bad  = r_bad || (c1 == BASE_BAD) || (c2 == BASE_BAD);
        n_seen = r_seen;
        if (is_acgt(c1)) begin
            n_seen[c1[1:0]] = 1'b1;
        end
        if (is_acgt(c2)) begin
            n_seen[c2[1:0]] = 1'b1;
        end

        for (int s = 0; s < 2; s++) begin
            n_het[s] = (het_item && (r_item.sex == 1'(s))) ? sat_count(r_het[s]) : r_het[s];
        end
        // Homozygous N matches no entry
        for (int k = 0; k < 8; k++) begin
            n_hom[k] = (!het_item && is_acgt(c1) && ({r_item.sex, c1[1:0]} == 3'(k)))
                       ? sat_count(r_hom[k]) : r_hom[k];
        end

        // Distinct bases in A, T, G, C order
        nb      = 3'($countones(n_seen));
        lo_base = 2'd0;
        hi_base = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (n_seen[i]) begin
                lo_base = 2'(i);
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (n_seen[i]) begin
                hi_base = 2'(i);
            end
        end
        x_base = r_item.swap_order ? hi_base : lo_base;
        y_base = r_item.swap_order ? lo_base : hi_base;

        // Contig start clears the counters only on a site's first item
        pos_base = (!r_mid_site && r_item.contig_start) ? 32'd0 : r_pos;
        seg_base = (!r_mid_site && r_item.contig_start) ? 32'd0 : r_seg;
        n_pos    = (pos_base == 32'hFFFF_FFFF) ? pos_base : pos_base + 32'd1;
        n_seg    = (!n_bad && (nb > 3'd1) && (seg_base != 32'hFFFF_FFFF))
                   ? seg_base + 32'd1 : seg_base;

        n_out_data                   = '0;
        n_out_data.site_position     = n_pos;
        n_out_data.segregating_sites = n_seg;
        n_out_status                 = ST_INVARIANT;
        if (n_bad) begin
            n_out_status = ST_BAD_BYTE;
        end else if (nb == 3'd2) begin
            n_out_data.allele_one     = x_base;
            n_out_data.allele_two     = y_base;
            n_out_data.female_hom_one = n_hom[{1'b0, x_base}];
            n_out_data.female_hom_two = n_hom[{1'b0, y_base}];
            n_out_data.female_het     = n_het[0];
            n_out_data.male_hom_one   = n_hom[{1'b1, x_base}];
            n_out_data.male_hom_two   = n_hom[{1'b1, y_base}];
            n_out_data.male_het       = n_het[1];
            // A sum of counts is zero exactly when every term is zero
            if (((n_out_data.female_hom_one | n_out_data.female_hom_two
                  | n_out_data.female_het) == '0) ||
                ((n_out_data.male_hom_one | n_out_data.male_hom_two
                  | n_out_data.male_het) == '0)) begin
                n_out_status = ST_ONE_SEX;
            end else begin
                n_out_status = ST_BIALLELIC;
            end
        end else if (nb == 3'd3) begin
            n_out_status = ST_THREE;
        end else if (nb == 3'd4) begin
            n_out_status = ST_FOUR;
        end
    end

    // Control and tally state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mid_site  <= 1'b0;
            r_seen      <= '0;
            r_bad       <= 1'b0;
            r_pos       <= '0;
            r_seg       <= '0;
            for (int k = 0; k < 8; k++) begin
                r_hom[k] <= '0;
            end
            for (int s = 0; s < 2; s++) begin
                r_het[s] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_item.last_of_site) begin
                    // Close the site: drop the tallies
                    r_mid_site <= 1'b0;
                    r_seen     <= '0;
                    r_bad      <= 1'b0;
                    r_pos      <= n_pos;
                    r_seg      <= n_seg;
                    for (int k = 0; k < 8; k++) begin
                        r_hom[k] <= '0;
                    end
                    for (int s = 0; s < 2; s++) begin
                        r_het[s] <= '0;
                    end
                end else begin
                    r_mid_site <= 1'b1;
                    r_seen     <= n_seen;
                    r_bad      <= n_bad;
                    r_pos      <= pos_base;
                    r_seg      <= seg_base;
                    r_hom      <= n_hom;
                    r_het      <= n_het;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.first_allele  <= s_axis_tdata[7:0];
            r_item.second_allele <= s_axis_tdata[15:8];
            r_item.sex           <= s_axis_tdata[16];
            r_item.swap_order    <= s_axis_tdata[17];
            r_item.contig_start  <= s_axis_tuser[0];
            r_item.last_of_site  <= s_axis_tlast;
        end
        if (adv_last) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

### rtl/sgsc_checker.sv
// Port-level checks for the sexed genotype site counter and their binding.
// Depends on sgsc_pkg and sexed_genotype_site_counter_core.
`default_nettype none

module sgsc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [sgsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [sgsc_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import sgsc_pkg::*;

    t_out_data rec;
    logic      kept;

    assign rec     = m_axis_tdata;
    assign kept    = (m_axis_tuser == ST_BIALLELIC) || (m_axis_tuser == ST_ONE_SEX);

    // A stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled record changed");

    // Records without a kept allele pair carry no alleles or counts
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !kept |-> (m_axis_tdata[121:64] == '0))
        else $error("non-biallelic record carries counts");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kept |-> (rec.allele_one != rec.allele_two))
        else $error("biallelic record with equal alleles");

    // Both sexes have data at a kept biallelic site
    a_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_BIALLELIC) |->
            ((rec.female_hom_one | rec.female_het | rec.female_hom_two) != '0) &&
            ((rec.male_hom_one | rec.male_het | rec.male_hom_two) != '0))
        else $error("kept site lacks one sex");

    // Position counts every site, so it never trails the segregating count
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (rec.site_position != 32'd0) && (rec.segregating_sites <= rec.site_position))
        else $error("site position behind segregating count");

endmodule

bind sexed_genotype_site_counter_core sgsc_checker u_sgsc_checker (.*);

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for sexed_genotype_site_counter_core: directed site table,
// one saturating site and random sites, scored by a genotype tally predictor or, for typed rows, by hand.
// Depends on sgsc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
    import sgsc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_OFF      = 300;
    localparam int RANDOM_ITEMS  = 120;
    localparam int SAT_RUN       = 258;
    localparam int N_DIR         = 21;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_AFTER    = 16;

    // Expected site record: status from tuser plus the tdata layout
    typedef struct packed {
        t_status   status;
        t_out_data data;
    } site_record_t;

    // One row of the directed table; typed rows carry their record by hand
    typedef struct {
        logic [7:0]  a1;
        logic [7:0]  a2;
        bit          sex;
        bit          swap;
        bit          cstart;
        bit          last;
        bit          typed;
        t_status     st;
        int unsigned pos;
        int unsigned seg;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // first_allele, second_allele, sex, swap_order
    logic [0:0]            s_axis_tuser;   // contig_start
    logic                  s_axis_tlast;   // last_of_site
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // position, segregating, alleles, six counts
    logic [STATUS_W-1:0]   m_axis_tuser;   // status

    sexed_genotype_site_counter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Predictor state: bases present, sexed tallies, contig counters
    logic [3:0]         bases_present;
    logic [COUNT_W-1:0] hom_tally [2][4];
    logic [COUNT_W-1:0] het_tally [2];
    bit                 bad_seen;
    bit                 site_open;
    logic [31:0]        pos_count;
    logic [31:0]        seg_count;

    site_record_t site_expect_q [$];
    site_record_t got_rec;
    site_record_t want_rec;

    int mismatches;
    int items_sent;
    int sites_checked;
    int status_hits [6];
    int idle_cycles = 0;
    int burst_left;
    bit gaps_on;
    dir_row_t dir_rows [N_DIR];

    // Map a raw byte to 0..3 for A,T,G,C, 4 for either N, 5 for anything else
    function automatic int base_index(input logic [7:0] b);
        if (b == CHAR_A) return 0;
        if (b == CHAR_T) return 1;
        if (b == CHAR_G) return 2;
        if (b == CHAR_C) return 3;
        if (b == CHAR_N_UPPER || b == CHAR_N_LOWER) return 4;
        return 5;
    endfunction

    task automatic clear_tallies();
        bases_present = '0;
        bad_seen      = 1'b0;
        for (int s = 0; s < 2; s++) begin
            het_tally[s] = '0;
            for (int b = 0; b < 4; b++) hom_tally[s][b] = '0;
        end
    endtask

    // Fold one individual into the site; on the closing item build the record
    task automatic tally_individual(input t_item it, output bit closes,
                                    output site_record_t rec);
        int         c1;
        int         c2;
        int         sx;
        int         nb;
        int         x;
        int         y;
        int         found [4];
        logic [10:0] f_sum;
        logic [10:0] m_sum;
        rec    = '0;
        closes = 1'b0;
        if (!site_open && it.contig_start) begin
            pos_count = '0;
            seg_count = '0;
        end
        site_open = 1'b1;
        c1 = base_index(it.first_allele);
        c2 = base_index(it.second_allele);
        sx = it.sex;
        if (c1 == 5 || c2 == 5) bad_seen = 1'b1;
        if (c1 < 4) bases_present[c1] = 1'b1;
        if (c2 < 4) bases_present[c2] = 1'b1;
        // Raw byte compare: N against n is heterozygous, homozygous N counts nowhere
        if (it.first_allele != it.second_allele) begin
            het_tally[sx] = (het_tally[sx] < COUNT_CAP) ? het_tally[sx] + 1'b1 : COUNT_CAP;
        end else if (c1 < 4) begin
            hom_tally[sx][c1] = (hom_tally[sx][c1] < COUNT_CAP) ?
                                hom_tally[sx][c1] + 1'b1 : COUNT_CAP;
        end
        if (!it.last_of_site) return;

        nb = 0;
        for (int b = 0; b < 4; b++) begin
            if (bases_present[b]) begin
                found[nb] = b;
                nb++;
            end
        end
        if (pos_count != '1) pos_count++;
        if (bad_seen) begin
            rec.status = ST_BAD_BYTE;
        end else begin
            if (nb > 1 && seg_count != '1) seg_count++;
            case (nb)
                2: begin
                    x = it.swap_order ? found[1] : found[0];
                    y = it.swap_order ? found[0] : found[1];
                    rec.data.allele_one     = 2'(x);
                    rec.data.allele_two     = 2'(y);
                    rec.data.female_hom_one = hom_tally[0][x];
                    rec.data.female_het     = het_tally[0];
                    rec.data.female_hom_two = hom_tally[0][y];
                    rec.data.male_hom_one   = hom_tally[1][x];
                    rec.data.male_het       = het_tally[1];
                    rec.data.male_hom_two   = hom_tally[1][y];
                    f_sum = 11'(hom_tally[0][x]) + 11'(hom_tally[0][y]) + 11'(het_tally[0]);
                    m_sum = 11'(hom_tally[1][x]) + 11'(hom_tally[1][y]) + 11'(het_tally[1]);
                    rec.status = (f_sum == 0 || m_sum == 0) ? ST_ONE_SEX : ST_BIALLELIC;
                end
                3:       rec.status = ST_THREE;
                4:       rec.status = ST_FOUR;
                default: rec.status = ST_INVARIANT;
            endcase
        end
        rec.data.site_position     = pos_count;
        rec.data.segregating_sites = seg_count;
        clear_tallies();
        site_open = 1'b0;
        closes    = 1'b1;
    endtask

    // Offer one item in bursts with random gaps; on acceptance predict and queue
    task automatic offer_item(input t_item it, input bit typed, input site_record_t typed_rec);
        int           gap;
        bit           closes;
        site_record_t rec;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gaps_on && gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.swap_order, it.sex, it.second_allele, it.first_allele};
        s_axis_tuser  <= it.contig_start;
        s_axis_tlast  <= it.last_of_site;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        tally_individual(it, closes, rec);
        if (closes) begin
            if (typed) rec = typed_rec;
            site_expect_q.push_back(rec);
            status_hits[rec.status]++;
        end
    endtask

    function automatic logic [7:0] pick_base(input logic [3:0] mask);
        int b;
        do b = $urandom_range(0, 3); while (!mask[b]);
        case (b)
            0:       return CHAR_A;
            1:       return CHAR_T;
            2:       return CHAR_G;
            default: return CHAR_C;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: site %0d %s mismatch, expected %0d got %0d",
                     $realtime, sites_checked, what, want, seen);
    endtask

    // Score every accepted record against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (site_expect_q.size() == 0) begin
                note_mismatch("unexpected record, status", 0, m_axis_tuser);
            end else begin
                want_rec      = site_expect_q.pop_front();
                got_rec       = {m_axis_tuser, m_axis_tdata};
                if (got_rec.status != want_rec.status)
                    note_mismatch("status", want_rec.status, got_rec.status);
                if (got_rec.data.site_position != want_rec.data.site_position)
                    note_mismatch("site_position", want_rec.data.site_position,
                                  got_rec.data.site_position);
                if (got_rec.data.segregating_sites != want_rec.data.segregating_sites)
                    note_mismatch("segregating_sites", want_rec.data.segregating_sites,
                                  got_rec.data.segregating_sites);
                if (got_rec.data.allele_one != want_rec.data.allele_one)
                    note_mismatch("allele_one", want_rec.data.allele_one,
                                  got_rec.data.allele_one);
                if (got_rec.data.allele_two != want_rec.data.allele_two)
                    note_mismatch("allele_two", want_rec.data.allele_two,
                                  got_rec.data.allele_two);
                if (got_rec.data.female_hom_one != want_rec.data.female_hom_one)
                    note_mismatch("female_hom_one", want_rec.data.female_hom_one,
                                  got_rec.data.female_hom_one);
                if (got_rec.data.female_het != want_rec.data.female_het)
                    note_mismatch("female_het", want_rec.data.female_het,
                                  got_rec.data.female_het);
                if (got_rec.data.female_hom_two != want_rec.data.female_hom_two)
                    note_mismatch("female_hom_two", want_rec.data.female_hom_two,
                                  got_rec.data.female_hom_two);
                if (got_rec.data.male_hom_one != want_rec.data.male_hom_one)
                    note_mismatch("male_hom_one", want_rec.data.male_hom_one,
                                  got_rec.data.male_hom_one);
                if (got_rec.data.male_het != want_rec.data.male_het)
                    note_mismatch("male_het", want_rec.data.male_het, got_rec.data.male_het);
                if (got_rec.data.male_hom_two != want_rec.data.male_hom_two)
                    note_mismatch("male_hom_two", want_rec.data.male_hom_two,
                                  got_rec.data.male_hom_two);
                if (got_rec.data.pad != '0)
                    note_mismatch("zero fill", 0, got_rec.data.pad);
            end
            sites_checked++;
        end
    end

    // Abort when neither side has moved an item for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: ready runs with short stalls, plus one long hold-off early in
    // the random phase that backs the core up until it stalls its input
    initial begin : receiver
        int  run;
        int  stall;
        bit  held_off;
        m_axis_tready = 1'b0;
        held_off      = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && sites_checked >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_OFF; k++) @(posedge i_clk);
            end
            run = $urandom_range(1, 24);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Main sequence: reset, directed table, saturating site, random sites, drain
    initial begin : main
        t_item        it;
        site_record_t typed_rec;
        int           random_items;
        int           len;
        int           r;
        logic [3:0]   mask;
        bit           one_sex;
        bit           site_sex;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        sites_checked = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        random_items  = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
        site_open     = 1'b0;
        pos_count     = '0;
        seg_count     = '0;
        clear_tallies();

        // a1, a2, sex, swap, contig_start, last, typed, status, position, segregating
        dir_rows = '{
            // single-item site straight after reset opens the contig
            '{CHAR_A, CHAR_A, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, ST_INVARIANT, 1, 0},
            // both sexes homozygous: kept biallelic
            '{CHAR_A, CHAR_A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_T, CHAR_T, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // heterozygous in both sexes, allele roles swapped; contig flag mid-site ignored
            '{CHAR_A, CHAR_T, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_T, CHAR_A, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // females only
            '{CHAR_G, CHAR_G, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_C, CHAR_C, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // three bases
            '{CHAR_A, CHAR_T, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_G, CHAR_G, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // four bases
            '{CHAR_A, CHAR_T, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_G, CHAR_C, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // N against n is heterozygous but adds no base
            '{CHAR_N_UPPER, CHAR_N_LOWER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_A, CHAR_A, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // homozygous N only: no base at all
            '{CHAR_N_UPPER, CHAR_N_UPPER, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            // bad bytes at the byte extremes, new contig on a single-item site
            '{8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, ST_BAD_BYTE, 1, 0},
            // bad byte buried mid-site poisons an otherwise biallelic site
            '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_A, CHAR_C, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, ST_BAD_BYTE, 2, 0},
            // lowercase a is not a base
            '{8'h61, CHAR_A, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ST_BAD_BYTE, 3, 0},
            '{CHAR_A, CHAR_A, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, ST_INVARIANT, 1, 0},
            '{CHAR_C, CHAR_G, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0},
            '{CHAR_N_LOWER, CHAR_N_LOWER, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ST_INVARIANT, 0, 0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            it = '{first_allele: dir_rows[i].a1, second_allele: dir_rows[i].a2,
                   sex: dir_rows[i].sex, swap_order: dir_rows[i].swap,
                   contig_start: dir_rows[i].cstart, last_of_site: dir_rows[i].last};
            typed_rec = '0;
            typed_rec.status                 = dir_rows[i].st;
            typed_rec.data.site_position     = dir_rows[i].pos;
            typed_rec.data.segregating_sites = dir_rows[i].seg;
            offer_item(it, dir_rows[i].typed, typed_rec);
        end

        // One long site, back to back: female hom A runs past the cap, then a
        // single male het C/A closes it
        gaps_on   = 1'b0;
        typed_rec = '0;
        for (int k = 0; k <= SAT_RUN; k++) begin
            it = '{first_allele: (k < SAT_RUN) ? CHAR_A : CHAR_C,
                   second_allele: CHAR_A,
                   sex: (k >= SAT_RUN), swap_order: 1'b0, contig_start: 1'b0,
                   last_of_site: (k == SAT_RUN)};
            offer_item(it, 1'b0, typed_rec);
        end
        gaps_on = 1'b1;

        // Random sites: mostly short, a few long; small base sets so biallelic
        // sites dominate, with sprinkled N calls and stray bytes
        while (random_items < RANDOM_ITEMS) begin
            len      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            mask     = 4'($urandom_range(1, 15));
            one_sex  = ($urandom_range(0, 3) == 0);
            site_sex = 1'($urandom_range(0, 1));
            for (int j = 0; j < len; j++) begin
                it.sex           = one_sex ? site_sex : 1'($urandom_range(0, 1));
                it.first_allele  = pick_base(mask);
                it.second_allele = ($urandom_range(0, 2) == 0) ? pick_base(mask)
                                                                : it.first_allele;
                r = $urandom_range(0, 99);
                if (r < 3)
                    it.second_allele = 8'($urandom_range(0, 255));
                else if (r < 6)
                    it.first_allele = 8'($urandom_range(0, 255));
                else if (r < 12)
                    it.first_allele = $urandom_range(0, 1) ? CHAR_N_UPPER : CHAR_N_LOWER;
                else if (r < 15) begin
                    it.first_allele  = CHAR_N_UPPER;
                    it.second_allele = CHAR_N_UPPER;
                end
                it.swap_order   = 1'($urandom_range(0, 1));
                it.contig_start = (j == 0) ? ($urandom_range(0, 11) == 0)
                                           : 1'($urandom_range(0, 1));
                it.last_of_site = (j == len - 1);
                offer_item(it, 1'b0, typed_rec);
                random_items++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (site_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d individuals, checked %0d site records, %0d mismatches.",
                 items_sent, sites_checked, mismatches);
        $display("Status mix inv/bi/one-sex/three/four/bad: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4], status_hits[5]);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
